// ===== rtl/core/shortest_remaining_time_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shortest remaining time scheduler
// Shared implication forms, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define SRTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/srts_pkg.sv =====
// ----------------------------------------------------------------------------
// srts_pkg
// Constants, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package srts_pkg;

  // Table and time sizing.
  localparam int MAX_PROCS  = 16;
  localparam int TIME_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_PROCS);
  localparam int CNT_BITS   = $clog2(MAX_PROCS + 1);
  localparam int CFG_BITS   = 5;
  localparam int FIELD_BITS = 16;
  // Wide enough for time, the 16-bit fields and one guard bit.
  localparam int CALC_BITS  = ((TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS) + 1;

  // Item modes.
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic        idle;
    logic [7:0]  run_id;
    logic [3:0]  run_slot;
    logic [15:0] time_end;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_step;
    logic sweep_wr;
    logic load_wr;
    logic update;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_mode;
    logic       n_zero;
    logic       scan_last;
    logic       sweep_last;
    logic       out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/srts_datapath.sv =====
// ----------------------------------------------------------------------------
// srts_datapath
// Process table, time counter, minimum search registers and result register.
// ----------------------------------------------------------------------------
module srts_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  srts_pkg::in_item_t           in_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srts_pkg::CFG_BITS-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output srts_pkg::out_item_t          out_data,
  input  srts_pkg::dp_cmd_t            cmd,
  output srts_pkg::dp_sts_t            sts
);
  import srts_pkg::*;

  logic [CFG_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  n_procs;
  in_item_t             item_r;

  logic [15:0]          arrival_mem [MAX_PROCS];
  logic [7:0]           id_mem      [MAX_PROCS];
  logic [15:0]          burst_mem   [MAX_PROCS];
  logic [15:0]          rem_mem     [MAX_PROCS];

  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] time_nxt;
  logic [CNT_BITS-1:0]  idx_r;
  logic [IDX_BITS-1:0]  pick_r;
  logic [15:0]          best_r;
  logic                 found_r;
  logic [1:0]           nz_r;

  logic [IDX_BITS-1:0]  addr;
  logic [IDX_BITS-1:0]  load_idx;
  logic                 load_ok;
  logic [15:0]          rd_arr;
  logic [15:0]          rd_burst;
  logic [15:0]          rd_rem;
  logic [7:0]           rd_id;
  logic                 eligible;
  logic                 better;

  logic [CALC_BITS-1:0] turn_w;
  logic [CALC_BITS-1:0] wait_w;
  logic [CALC_BITS-1:0] time_ext;
  logic                 fin;
  logic                 done;

  out_item_t            out_r;
  logic                 out_valid_r;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CFG_BITS'(MAX_PROCS);
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // Counts above the table size take the whole table.
  always_comb begin
    if (int'(count_r) > MAX_PROCS) begin
      n_procs = CNT_BITS'(MAX_PROCS);
    end else begin
      n_procs = CNT_BITS'(count_r);
    end
  end

  // Hold the accepted item while it is worked on.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  // One shared read port: the chosen slot on update, otherwise the scan index.
  assign addr     = cmd.update ? pick_r : idx_r[IDX_BITS-1:0];
  assign rd_arr   = arrival_mem[addr];
  assign rd_burst = burst_mem[addr];
  assign rd_rem   = rem_mem[addr];
  assign rd_id    = id_mem[addr];

  assign load_ok  = int'(item_r.slot) < MAX_PROCS;
  assign load_idx = IDX_BITS'(item_r.slot);

  // Scan compare against the running minimum.
  assign eligible = (CALC_BITS'(rd_arr) <= CALC_BITS'(time_r)) && (rd_rem != 16'd0);
  assign better   = eligible && (!found_r || (rd_rem < best_r));

  // Identifier and arrival stores hold no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      arrival_mem[load_idx] <= item_r.arrival;
      id_mem[load_idx]      <= item_r.proc_id;
    end
  end

  // Burst and remaining stores clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        burst_mem[i] <= 16'd0;
        rem_mem[i]   <= 16'd0;
      end
    end else begin
      if (cmd.load_wr) begin
        if (load_ok) begin
          burst_mem[load_idx] <= item_r.burst;
          rem_mem[load_idx]   <= item_r.burst;
        end
      end else if (cmd.sweep_wr) begin
        rem_mem[addr] <= rd_burst;
      end else if (cmd.update && found_r) begin
        rem_mem[pick_r] <= best_r - 16'd1;
      end
    end
  end

  // Scan index and minimum search state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      pick_r  <= '0;
      best_r  <= 16'd0;
      found_r <= 1'b0;
      nz_r    <= 2'd0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r   <= '0;
        pick_r  <= '0;
        best_r  <= 16'd0;
        found_r <= 1'b0;
        nz_r    <= 2'd0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + CNT_BITS'(1);
        if ((rd_rem != 16'd0) && (nz_r != 2'd2)) begin
          nz_r <= nz_r + 2'd1;
        end
        if (better) begin
          found_r <= 1'b1;
          best_r  <= rd_rem;
          pick_r  <= addr;
        end
      end else if (cmd.sweep_wr) begin
        idx_r <= idx_r + CNT_BITS'(1);
      end
    end
  end

  // Saturating time counter.
  assign time_nxt = (time_r == '1) ? time_r : time_r + TIME_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (cmd.sweep_wr) begin
      time_r <= '0;
    end else if (cmd.update) begin
      time_r <= time_nxt;
    end
  end

  // Finish figures; the chosen slot has always arrived, so no underflow.
  assign time_ext = CALC_BITS'(time_nxt);
  assign turn_w   = time_ext - CALC_BITS'(rd_arr);
  assign wait_w   = (turn_w > CALC_BITS'(rd_burst)) ? turn_w - CALC_BITS'(rd_burst) : '0;
  assign fin      = found_r && (best_r == 16'd1);
  assign done     = found_r ? ((nz_r == 2'd1) && (best_r == 16'd1)) : (nz_r == 2'd0);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.idle       <= !found_r;
      out_r.run_id     <= found_r ? rd_id : 8'd0;
      out_r.run_slot   <= found_r ? 4'(pick_r) : 4'd0;
      out_r.time_end   <= time_ext[15:0];
      out_r.finished   <= fin;
      out_r.all_done   <= done;
      if (fin) begin
        out_r.turnaround <= (turn_w > CALC_BITS'(16'hFFFF)) ? 16'hFFFF : turn_w[15:0];
        out_r.waiting    <= (wait_w > CALC_BITS'(16'hFFFF)) ? 16'hFFFF : wait_w[15:0];
      end else begin
        out_r.turnaround <= 16'd0;
        out_r.waiting    <= 16'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller.
  assign sts.in_mode    = in_data.mode;
  assign sts.n_zero     = (n_procs == '0);
  assign sts.scan_last  = (idx_r == n_procs - CNT_BITS'(1));
  assign sts.sweep_last = (idx_r == CNT_BITS'(MAX_PROCS - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

// ===== rtl/core/srts_ctrl.sv =====
// ----------------------------------------------------------------------------
// srts_ctrl
// Sequencer for load, restart sweep, minimum scan and tick update.
// ----------------------------------------------------------------------------
`include "shortest_remaining_time_scheduler_top_macros.svh"

module srts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output srts_pkg::dp_cmd_t cmd,
  input  srts_pkg::dp_sts_t sts
);
  import srts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RESTART,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign accept = in_valid && !in_stall_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch    = 1'b1;
          cmd.scan_clr = 1'b1;
          unique case (sts.in_mode)
            MODE_LOAD:    state_nxt = ST_LOAD;
            MODE_TICK:    state_nxt = ST_SCAN;
            MODE_RESTART: state_nxt = ST_RESTART;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_RESTART: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.n_zero) begin
          state_nxt = ST_UPDATE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  // Checks on the sequencing.
  `SRTS_ASSERT_NOW(a_busy_stalls, clk, rst_n, state_r != ST_IDLE, in_stall_r, "input open while busy")
  `SRTS_ASSERT_NOW(a_update_room, clk, rst_n, cmd.update, !sts.out_busy, "result register overwritten")
  `SRTS_ASSERT_NEXT(a_restart_go, clk, rst_n, accept && (sts.in_mode == MODE_RESTART), state_r == ST_RESTART, "restart not started")
  `SRTS_ASSERT_NEXT(a_tick_go, clk, rst_n, accept && (sts.in_mode == MODE_TICK), state_r == ST_SCAN, "tick not started")

endmodule

// ===== rtl/core/shortest_remaining_time_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top
// Shortest remaining time first scheduler over a sixteen-slot process table.
// ----------------------------------------------------------------------------
// A load item is accepted and then written into the table. A restart
// copies the remaining times from the burst store one slot at a time,
// over every table slot. A tick scans each counted slot (the configured
// process count, at most sixteen) through the single table read port and
// then does one update. The update waits while an earlier result is still
// stalled in the output register. Only tick items give a result.
module shortest_remaining_time_scheduler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srts_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output srts_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srts_pkg::CFG_BITS-1:0] cfg_data
);
  import srts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  srts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Table, search and result datapath.
  srts_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== tb/tb_shortest_remaining_time_scheduler_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shortest_remaining_time_scheduler_top
// Self-checking bench for the shortest remaining time scheduler. Loads,
// restarts and ticks are driven through the valid/stall input channel, and
// each tick transfer is predicted by a behavioural model of the process
// table. Every result transfer is compared field by field with the oldest
// prediction. The run covers directed corner cases, randomised schedules
// under several process counts, a long output hold-off and a stretch of
// traffic with no idling on either side.
// ----------------------------------------------------------------------------
module tb_shortest_remaining_time_scheduler_top;
  import srts_pkg::*;

  // Mode code that the block does not use and must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int QUIET_TICKS   = 80;

  // Behavioural model of the process table and the expected tick results.
  class srtf_checker;
    bit [7:0]          id_tab[MAX_PROCS];
    bit [15:0]         arrival_tab[MAX_PROCS];
    bit [15:0]         burst_tab[MAX_PROCS];
    bit [15:0]         left_tab[MAX_PROCS];
    bit [15:0]         clock_now;
    bit [CFG_BITS-1:0] count_reg;
    out_item_t         expected_ticks[$];
    int                errors;
    int                items;
    int                ticks;
    int                finishes;
    int                idles;

    function new();
      count_reg = CFG_BITS'(MAX_PROCS);
    endfunction

    function int counted();
      return (count_reg > MAX_PROCS) ? MAX_PROCS : int'(count_reg);
    endfunction

    // True when no counted slot has any remaining time.
    function bit all_slots_clear();
      bit clear;
      clear = 1'b1;
      for (int i = 0; i < counted(); i++)
        if (left_tab[i] != 0) clear = 1'b0;
      return clear;
    endfunction

    // Runs one tick on the model and returns the result it should give.
    function out_item_t predict_tick();
      out_item_t r;
      bit        found;
      int        pick;
      bit [15:0] best;
      int        turn;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      best  = '0;
      for (int i = 0; i < counted(); i++) begin
        if (arrival_tab[i] <= clock_now && left_tab[i] != 0 &&
            (!found || left_tab[i] < best)) begin
          found = 1'b1;
          best  = left_tab[i];
          pick  = i;
        end
      end
      if (clock_now != 16'hFFFF) clock_now++;
      r.idle     = !found;
      r.time_end = clock_now;
      if (found) begin
        left_tab[pick]--;
        r.run_id   = id_tab[pick];
        r.run_slot = pick[3:0];
        if (left_tab[pick] == 0) begin
          turn         = int'(clock_now) - int'(arrival_tab[pick]);
          r.finished   = 1'b1;
          r.turnaround = (turn > 65535) ? 16'hFFFF : turn[15:0];
          r.waiting    = (turn > int'(burst_tab[pick])) ?
                         16'(turn - int'(burst_tab[pick])) : 16'd0;
          finishes++;
        end
      end else begin
        idles++;
      end
      r.all_done = all_slots_clear();
      return r;
    endfunction

    // Notes an accepted input transfer.
    function void note_item(in_item_t it);
      items++;
      case (it.mode)
        MODE_LOAD: begin
          id_tab[it.slot]      = it.proc_id;
          arrival_tab[it.slot] = it.arrival;
          burst_tab[it.slot]   = it.burst;
          left_tab[it.slot]    = it.burst;
        end
        MODE_RESTART: begin
          for (int i = 0; i < MAX_PROCS; i++) left_tab[i] = burst_tab[i];
          clock_now = '0;
        end
        MODE_TICK: begin
          ticks++;
          expected_ticks.push_back(predict_tick());
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    // Compares a result transfer with the oldest expected tick.
    task check_tick(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        report("result transfer with no tick outstanding");
      end else begin
        want = expected_ticks.pop_front();
        check_field("idle", 16'(got.idle), 16'(want.idle));
        check_field("run_id", 16'(got.run_id), 16'(want.run_id));
        check_field("run_slot", 16'(got.run_slot), 16'(want.run_slot));
        check_field("time_end", got.time_end, want.time_end);
        check_field("finished", 16'(got.finished), 16'(want.finished));
        check_field("turnaround", got.turnaround, want.turnaround);
        check_field("waiting", got.waiting, want.waiting);
        check_field("all_done", 16'(got.all_done), 16'(want.all_done));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  srtf_checker sb = new;
  bit          quiet;
  bit          held;
  int          rx_count;
  int          cfg_writes;

  shortest_remaining_time_scheduler_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so that the block
  // fills up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && rx_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 27);
    end
  end

  // Check every result transfer at the clock edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_count++;
      sb.check_tick(out_data);
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, logic [3:0] slot,
                                         logic [7:0] id, logic [15:0] arrival,
                                         logic [15:0] burst);
    in_item_t it;
    it.mode    = mode;
    it.slot    = slot;
    it.proc_id = id;
    it.arrival = arrival;
    it.burst   = burst;
    return it;
  endfunction

  // An item of the given mode with random contents in the unused fields.
  function automatic in_item_t rand_item(logic [1:0] mode);
    return make_item(mode, 4'($urandom_range(15)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)));
  endfunction

  // A load with mostly short bursts and early arrivals, now and then wide.
  function automatic in_item_t rand_load(logic [3:0] slot);
    logic [15:0] arrival;
    logic [15:0] burst;
    arrival = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                       : 16'($urandom_range(12));
    burst   = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                       : 16'($urandom_range(6));
    return make_item(MODE_LOAD, slot, 8'($urandom_range(255)), arrival, burst);
  endfunction

  // Offers one item and returns at the falling edge after its transfer.
  task automatic send(input in_item_t item);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(item);
    @(negedge clk);
  endtask

  // Waits until every tick has reported and any load or restart has ended.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.count_reg = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Short hand-written schedule on four slots: ties, late arrival, a slot
  // that never arrives, restart, the unused mode and a count of zero.
  task automatic directed();
    write_count(5'd4);
    send(make_item(MODE_LOAD, 4'd0, 8'h00, 16'd0, 16'd3));
    send(make_item(MODE_LOAD, 4'd1, 8'hFF, 16'd2, 16'd1));
    send(make_item(MODE_LOAD, 4'd2, 8'hA5, 16'hFFFF, 16'hFFFF));
    send(make_item(MODE_LOAD, 4'd3, 8'h5A, 16'd0, 16'd3));
    send(rand_item(MODE_UNUSED));
    repeat (9) send(rand_item(MODE_TICK));
    send(rand_item(MODE_RESTART));
    repeat (2) send(rand_item(MODE_TICK));
    write_count(5'd0);
    repeat (2) send(rand_item(MODE_TICK));
  endtask

  // Random schedules: reload some slots, usually restart, then tick until
  // the table drains or a cap is hit, with occasional noise in between.
  task automatic random_phase();
    int             sent;
    int             cap;
    int unsigned    pick;
    logic [CFG_BITS-1:0] count;
    sent = 0;
    // Every slot is written before any tick can scan it.
    for (int s = 0; s < MAX_PROCS; s++) begin
      send(rand_load(4'(s)));
      sent++;
    end
    write_count(5'd31);
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(9);
        if (pick == 0)      count = 5'd0;
        else if (pick == 1) count = 5'($urandom_range(31, 17));
        else if (pick == 2) count = 5'd16;
        else                count = 5'($urandom_range(16, 1));
        write_count(count);
      end
      repeat ($urandom_range(6, 1)) begin
        send(rand_load(4'($urandom_range(15))));
        sent++;
      end
      if ($urandom_range(4) != 0) begin
        send(rand_item(MODE_RESTART));
        sent++;
      end
      cap = $urandom_range(60, 10);
      for (int t = 0; t < cap; t++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send(rand_item(MODE_UNUSED));
        end else if (pick < 6) begin
          send(rand_load(4'($urandom_range(15))));
          sent++;
        end else if (pick < 8) begin
          send(rand_item(MODE_RESTART));
          sent++;
        end else begin
          send(rand_item(MODE_TICK));
          sent++;
        end
        if (sb.all_slots_clear() && t >= 2) break;
      end
    end
  endtask

  // A run of loads, a restart and ticks with no idling on either side.
  task automatic quiet_phase();
    write_count(5'd16);
    quiet = 1'b1;
    for (int s = 0; s < 4; s++) send(rand_load(4'(s)));
    send(rand_item(MODE_RESTART));
    repeat (QUIET_TICKS) send(rand_item(MODE_TICK));
    quiet = 1'b0;
  endtask

  // Main sequence.
  initial begin
    int drain;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed();
    random_phase();
    quiet_phase();

    in_valid <= 1'b0;
    for (drain = 0; drain < DRAIN_LIMIT && sb.expected_ticks.size() != 0; drain++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.expected_ticks.size() != 0)
      sb.report($sformatf("%0d ticks never gave a result", sb.expected_ticks.size()));

    $display("Run summary: %0d input transfers, %0d ticks, %0d finishes, %0d idle ticks.",
             sb.items, sb.ticks, sb.finishes, sb.idles);
    $display("Process count written %0d times; one long result hold-off and a gap-free run.",
             cfg_writes);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
